// File: rtl/pcdq_pkg.sv
// ----------------------------------------------------------------------------
// pcdq_pkg
// shared constants, sine table and microcode for the phase current d/q block
// ----------------------------------------------------------------------------
package pcdq_pkg;

	// block configuration
	localparam int OFFSET_SHIFT     = 6;
	localparam int SAMPLE_BITS      = 12;
	localparam int SINE_TABLE_DEPTH = 1024;

	// fixed field widths
	localparam int ANGLE_W = 16;
	localparam int OUT_W   = 19;

	// datapath widths
	localparam int OFF_W  = SAMPLE_BITS + OFFSET_SHIFT;
	localparam int CORR_W = OFF_W + 1;
	localparam int U_W    = CORR_W + 2;
	localparam int V_W    = CORR_W + 1;
	localparam int XY_W   = U_W + 16;
	localparam int LO_W   = (XY_W + 1) / 2;
	localparam int HI_W   = XY_W - LO_W;
	localparam int MA_W   = (U_W > LO_W + 1) ? U_W : LO_W + 1;
	localparam int MB_W   = 18;
	localparam int P_W    = MA_W + MB_W;
	localparam int ACC_W  = XY_W + 19;
	localparam int RSH    = 31 + OFFSET_SHIFT - 4;

	// trig format: q15 magnitude from the table, signed after quadrant fold
	localparam int ROM_W        = 16;
	localparam int TRIG_W       = ROM_W + 1;
	localparam int POS_W        = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int QUARTER_TURN = 1 << (ANGLE_W - 2);

	// q16 transform constants
	localparam int THIRD_Q16     = 21845;
	localparam int INV_SQRT3_Q16 = 37837;

	localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
	localparam int OUT_MIN = -(1 << (OUT_W - 1));

	// quarter-wave sine table, taylor series in q30
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

	typedef logic [ROM_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

	function automatic logic [ROM_W-1:0] quarter_sine(input int i);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] r;
		x = (PI_HALF_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
		term = x;
		sum = x;
		for (int k = 1; k <= 6; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / TAYLOR_DIV[k-1];
			if (k % 2 == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		r = (sum + 64'd16384) >> 15;
		if (r > 64'd32768)
			r = 64'd32768;
		return r[ROM_W-1:0];
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t t;
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
			t[i] = quarter_sine(i);
		return t;
	endfunction

	localparam sine_rom_t SINE_TABLE = build_sine();

	// sine unit request
	typedef struct packed {
		logic               rd;
		logic [ANGLE_W-1:0] angle;
	} trig_req_t;

	// sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE, ST_CORR, ST_UV, ST_MX, ST_MY, ST_D0, ST_D1, ST_D2,
		ST_D3, ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_QSUM, ST_OUT
	} step_t;

	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_WAIT_OUT} jump_t;
	typedef enum logic [2:0] {OPA_U, OPA_V, OPA_XL, OPA_XH, OPA_YL, OPA_YH} opa_t;
	typedef enum logic [1:0] {OPB_THIRD, OPB_ISQ3, OPB_COS, OPB_SIN} opb_t;
	typedef enum logic [2:0] {
		ACC_NOP, ACC_TO_X, ACC_TO_Y, ACC_LOAD, ACC_ADD, ACC_SUB
	} acc_op_t;
	typedef enum logic [1:0] {CAP_NONE, CAP_SIN, CAP_COS} trig_cap_t;

	typedef struct packed {
		jump_t     jmp;
		step_t     next;
		logic      mul_en;
		opa_t      opa;
		opb_t      opb;
		acc_op_t   acc_op;
		logic      acc_hi;
		logic      rom_rd;
		logic      rom_cos;
		trig_cap_t trig_cap;
		logic      ld_corr;
		logic      ld_uv;
		logic      ld_d;
		logic      ld_out;
	} ucode_t;

	localparam ucode_t UC_NOP = '{
		jmp: JMP_NEXT, next: ST_IDLE, mul_en: 1'b0, opa: OPA_U, opb: OPB_THIRD,
		acc_op: ACC_NOP, acc_hi: 1'b0, rom_rd: 1'b0, rom_cos: 1'b0,
		trig_cap: CAP_NONE, ld_corr: 1'b0, ld_uv: 1'b0, ld_d: 1'b0, ld_out: 1'b0
	};

	// control store: one word per step
	function automatic ucode_t ucode(input step_t s);
		ucode_t w;
		w = UC_NOP;
		unique case (s)
			ST_IDLE: begin
				w.jmp = JMP_WAIT_IN;
				w.next = ST_CORR;
			end
			ST_CORR: begin
				w.next = ST_UV;
				w.ld_corr = 1'b1;
				w.rom_rd = 1'b1;
			end
			ST_UV: begin
				w.next = ST_MX;
				w.ld_uv = 1'b1;
				w.rom_rd = 1'b1;
				w.rom_cos = 1'b1;
				w.trig_cap = CAP_SIN;
			end
			ST_MX: begin
				w.next = ST_MY;
				w.trig_cap = CAP_COS;
				w.mul_en = 1'b1;
				w.opa = OPA_U;
				w.opb = OPB_THIRD;
			end
			ST_MY: begin
				w.next = ST_D0;
				w.mul_en = 1'b1;
				w.opa = OPA_V;
				w.opb = OPB_ISQ3;
				w.acc_op = ACC_TO_X;
			end
			ST_D0: begin
				w.next = ST_D1;
				w.mul_en = 1'b1;
				w.opa = OPA_XL;
				w.opb = OPB_COS;
				w.acc_op = ACC_TO_Y;
			end
			ST_D1: begin
				w.next = ST_D2;
				w.mul_en = 1'b1;
				w.opa = OPA_XH;
				w.opb = OPB_COS;
				w.acc_op = ACC_LOAD;
			end
			ST_D2: begin
				w.next = ST_D3;
				w.mul_en = 1'b1;
				w.opa = OPA_YL;
				w.opb = OPB_SIN;
				w.acc_op = ACC_ADD;
				w.acc_hi = 1'b1;
			end
			ST_D3: begin
				w.next = ST_Q0;
				w.mul_en = 1'b1;
				w.opa = OPA_YH;
				w.opb = OPB_SIN;
				w.acc_op = ACC_ADD;
			end
			ST_Q0: begin
				w.next = ST_Q1;
				w.mul_en = 1'b1;
				w.opa = OPA_YL;
				w.opb = OPB_COS;
				w.acc_op = ACC_ADD;
				w.acc_hi = 1'b1;
			end
			ST_Q1: begin
				w.next = ST_Q2;
				w.mul_en = 1'b1;
				w.opa = OPA_YH;
				w.opb = OPB_COS;
				w.acc_op = ACC_LOAD;
				w.ld_d = 1'b1;
			end
			ST_Q2: begin
				w.next = ST_Q3;
				w.mul_en = 1'b1;
				w.opa = OPA_XL;
				w.opb = OPB_SIN;
				w.acc_op = ACC_ADD;
				w.acc_hi = 1'b1;
			end
			ST_Q3: begin
				w.next = ST_QSUM;
				w.mul_en = 1'b1;
				w.opa = OPA_XH;
				w.opb = OPB_SIN;
				w.acc_op = ACC_SUB;
			end
			ST_QSUM: begin
				w.next = ST_OUT;
				w.acc_op = ACC_SUB;
				w.acc_hi = 1'b1;
			end
			ST_OUT: begin
				w.jmp = JMP_WAIT_OUT;
				w.next = ST_IDLE;
				w.ld_out = 1'b1;
			end
			default: w.next = ST_IDLE;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/pcdq_sine_rom.sv
// ----------------------------------------------------------------------------
// pcdq_sine_rom
// signed q15 sine of a 16-bit angle from a quarter-wave table, registered read
// ----------------------------------------------------------------------------
module pcdq_sine_rom (
	input  logic                                clk,
	input  pcdq_pkg::trig_req_t                 req,
	output logic signed [pcdq_pkg::TRIG_W-1:0]  value
);
	import pcdq_pkg::*;

	localparam int R_W   = ANGLE_W - 2;
	localparam int IDX_W = R_W + POS_W;

	logic [1:0]       quad;
	logic [IDX_W-1:0] scaled;
	logic [POS_W-1:0] idx;
	logic [POS_W-1:0] pos;
	logic [ROM_W-1:0] rom_q;
	logic             neg_q;

	// quadrant fold: mirror in odd quadrants
	always_comb begin
		quad = req.angle[ANGLE_W-1:ANGLE_W-2];
		scaled = IDX_W'(req.angle[R_W-1:0]) * IDX_W'(SINE_TABLE_DEPTH);
		idx = scaled[IDX_W-1 -: POS_W];
		pos = quad[0] ? POS_W'(SINE_TABLE_DEPTH) - idx : idx;
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rom_q <= SINE_TABLE[pos];
			neg_q <= quad[1];
		end
	end

	// negative half turn
	assign value = neg_q ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

endmodule

// File: rtl/phase_current_dq_transform.sv
// ----------------------------------------------------------------------------
// phase_current_dq_transform
// offset-corrected three-phase currents to d/q axis currents
// ----------------------------------------------------------------------------
// usage:
//   sample channel: angle plus three phase and three reference readings, one
//   word taken when sample_valid is high and sample_stall is low
//   result channel: d_current and q_current, taken when result_valid is high
//   and result_stall is low
//   each word steps the three running offsets by (ref - offset)/64, removes
//   them from the phase readings and applies the 2/3-scaled dq0 transform
//   a word runs through the sequencer steps from acceptance until its result
//   is loaded into the output register; the next word is taken only once the
//   sequencer is back at idle, a limit set by the one shared 21x18 multiplier
//   that the microcode runs through ten partial products
//   the output register holds a finished result while the next word is
//   worked on; a stalled receiver holds the sequencer only at its last step
//   reset clears the offsets, the sequencer and result_valid
// ----------------------------------------------------------------------------
module phase_current_dq_transform (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic [pcdq_pkg::ANGLE_W-1:0]           angle,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       phase_u_sample,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       phase_v_sample,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       phase_w_sample,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       ref_u_sample,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       ref_v_sample,
	input  logic [pcdq_pkg::SAMPLE_BITS-1:0]       ref_w_sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [pcdq_pkg::OUT_W-1:0]      d_current,
	output logic signed [pcdq_pkg::OUT_W-1:0]      q_current
);
	import pcdq_pkg::*;

	// phase slots
	localparam int PH_U = 0;
	localparam int PH_V = 1;
	localparam int PH_W = 2;

	localparam logic signed [ACC_W-1:0] RND_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (RSH - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(OUT_MAX);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(OUT_MIN);

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		if (v > SAT_HI)
			return SAT_HI[OUT_W-1:0];
		if (v < SAT_LO)
			return SAT_LO[OUT_W-1:0];
		return v[OUT_W-1:0];
	endfunction

	// sequencer
	step_t  step_q;
	step_t  step_d;
	ucode_t uc;
	logic   hold;
	logic   accept;
	logic   out_fire;

	// datapath registers
	logic [ANGLE_W-1:0]       angle_q;
	logic [SAMPLE_BITS-1:0]   samp_q [3];
	logic [OFF_W-1:0]         off_q [3];
	logic signed [CORR_W-1:0] corr_q [3];
	logic signed [U_W-1:0]    u_q;
	logic signed [V_W-1:0]    v_q;
	logic signed [TRIG_W-1:0] sf_q;
	logic signed [TRIG_W-1:0] cf_q;
	logic signed [P_W-1:0]    prod_q;
	logic signed [XY_W-1:0]   x_q;
	logic signed [XY_W-1:0]   y_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [OUT_W-1:0]  dres_q;
	logic signed [OUT_W-1:0]  d_q;
	logic signed [OUT_W-1:0]  q_q;
	logic                     res_valid_q;

	// combinational datapath
	logic [SAMPLE_BITS-1:0]   ph_in [3];
	logic [SAMPLE_BITS-1:0]   lvl_in [3];
	logic signed [OFF_W:0]    off_diff [3];
	logic signed [OFF_W:0]    off_sum [3];
	logic [OFF_W-1:0]         off_nxt [3];
	logic signed [MA_W-1:0]   op_a;
	logic signed [MB_W-1:0]   op_b;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  acc_rnd;
	logic signed [ACC_W-1:0]  rnd;
	trig_req_t                trig_req;
	logic signed [TRIG_W-1:0] trig_val;

	assign ph_in[PH_U]  = phase_u_sample;
	assign ph_in[PH_V]  = phase_v_sample;
	assign ph_in[PH_W]  = phase_w_sample;
	assign lvl_in[PH_U] = ref_u_sample;
	assign lvl_in[PH_V] = ref_v_sample;
	assign lvl_in[PH_W] = ref_w_sample;

	// control word for the current step
	assign uc = ucode(step_q);

	// only the idle step takes a word
	assign sample_stall = (step_q != ST_IDLE);
	assign accept       = sample_valid && (step_q == ST_IDLE);

	always_comb begin
		unique case (uc.jmp)
			JMP_WAIT_IN:  hold = !sample_valid;
			JMP_WAIT_OUT: hold = res_valid_q && result_stall;
			default:      hold = 1'b0;
		endcase
		step_d = hold ? step_q : uc.next;
		out_fire = uc.ld_out && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	// offset update: off += floor(((ref << shift) - off) / 2^shift)
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off_diff[i] = $signed({1'b0, lvl_in[i], {OFFSET_SHIFT{1'b0}}})
				- $signed({1'b0, off_q[i]});
			off_sum[i] = $signed({1'b0, off_q[i]}) + (off_diff[i] >>> OFFSET_SHIFT);
			off_nxt[i] = off_sum[i][OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++)
				off_q[i] <= '0;
		end else if (accept) begin
			for (int i = 0; i < 3; i++)
				off_q[i] <= off_nxt[i];
		end
	end

	// sine unit, one read per step, sine then cosine
	assign trig_req.rd    = uc.rom_rd;
	assign trig_req.angle = uc.rom_cos ? angle_q + ANGLE_W'(QUARTER_TURN) : angle_q;

	pcdq_sine_rom u_sine (
		.clk   (clk),
		.req   (trig_req),
		.value (trig_val)
	);

	// shared multiplier operands
	always_comb begin
		unique case (uc.opa)
			OPA_U:   op_a = MA_W'(u_q);
			OPA_V:   op_a = MA_W'(v_q);
			OPA_XL:  op_a = MA_W'({1'b0, x_q[LO_W-1:0]});
			OPA_XH:  op_a = MA_W'($signed(x_q[XY_W-1:LO_W]));
			OPA_YL:  op_a = MA_W'({1'b0, y_q[LO_W-1:0]});
			OPA_YH:  op_a = MA_W'($signed(y_q[XY_W-1:LO_W]));
			default: op_a = '0;
		endcase
		unique case (uc.opb)
			OPB_THIRD: op_b = MB_W'(THIRD_Q16);
			OPB_ISQ3:  op_b = MB_W'(INV_SQRT3_Q16);
			OPB_COS:   op_b = MB_W'(cf_q);
			OPB_SIN:   op_b = MB_W'(sf_q);
			default:   op_b = '0;
		endcase
	end

	// partial products of the high halves land LO_W bits up
	always_comb begin
		prod_ext = ACC_W'(prod_q);
		addend = uc.acc_hi ? (prod_ext <<< LO_W) : prod_ext;
		acc_rnd = acc_q + RND_HALF;
		rnd = acc_rnd >>> RSH;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			angle_q <= angle;
			for (int i = 0; i < 3; i++)
				samp_q[i] <= ph_in[i];
		end
		if (uc.ld_corr) begin
			for (int i = 0; i < 3; i++)
				corr_q[i] <= $signed({1'b0, samp_q[i], {OFFSET_SHIFT{1'b0}}})
					- $signed({1'b0, off_q[i]});
		end
		// a = U, b = W, c = V
		if (uc.ld_uv) begin
			u_q <= (U_W'(corr_q[PH_U]) <<< 1) - U_W'(corr_q[PH_W]) - U_W'(corr_q[PH_V]);
			v_q <= V_W'(corr_q[PH_W]) - V_W'(corr_q[PH_V]);
		end
		case (uc.trig_cap)
			CAP_SIN: sf_q <= trig_val;
			CAP_COS: cf_q <= trig_val;
			default: ;
		endcase
		if (uc.mul_en)
			prod_q <= op_a * op_b;
		case (uc.acc_op)
			ACC_TO_X: x_q <= prod_q[XY_W-1:0];
			ACC_TO_Y: y_q <= prod_q[XY_W-1:0];
			ACC_LOAD: acc_q <= addend;
			ACC_ADD:  acc_q <= acc_q + addend;
			ACC_SUB:  acc_q <= acc_q - addend;
			default:  ;
		endcase
		// d sum is complete when the q sum starts
		if (uc.ld_d)
			dres_q <= sat_out(rnd);
		if (out_fire) begin
			d_q <= dres_q;
			q_q <= sat_out(rnd);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid = res_valid_q;
	assign d_current    = d_q;
	assign q_current    = q_q;

endmodule

// File: bench/phase_current_dq_transform_tb.sv
// ----------------------------------------------------------------------------
// phase_current_dq_transform_tb
// self-checking bench for the offset-corrected d/q current transform: every
// accepted sample word runs through a local bit-exact predictor of the three
// running offsets, the sine lookup and the 2/3-scaled dq0 sums, and every
// result word is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module phase_current_dq_transform_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import pcdq_pkg::ANGLE_W;
	import pcdq_pkg::SAMPLE_BITS;
	import pcdq_pkg::OUT_W;
	import pcdq_pkg::OFFSET_SHIFT;
	import pcdq_pkg::SINE_TABLE_DEPTH;

	// predictor constants, q16 transform weights and the final scaling
	localparam longint THIRD_W      = 21845;
	localparam longint ISQRT3_W     = 37837;
	localparam int     OUT_SHIFT    = 31 + OFFSET_SHIFT - 4;
	localparam longint OUT_HI       = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LO       = -(longint'(1) <<< (OUT_W - 1));
	localparam int     LEVEL_MAX    = (1 << SAMPLE_BITS) - 1;

	// bench timing
	localparam int QUIET_LIMIT  = 2000;	// cycles without any word moving on either channel
	localparam int HOLDOFF_LEN  = 300;	// long receiver hold-off
	localparam int DRAIN_CYCLES = 40;	// settling after the last expected result

	typedef struct packed {
		logic [ANGLE_W-1:0]     angle;
		logic [SAMPLE_BITS-1:0] pu;
		logic [SAMPLE_BITS-1:0] pv;
		logic [SAMPLE_BITS-1:0] pw;
		logic [SAMPLE_BITS-1:0] ru;
		logic [SAMPLE_BITS-1:0] rv;
		logic [SAMPLE_BITS-1:0] rw;
	} sample_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] d;
		logic signed [OUT_W-1:0] q;
	} dq_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// sample channel, driven at the falling edge
	logic                   sample_valid = 1'b0;
	logic                   sample_stall;
	logic [ANGLE_W-1:0]     angle = '0;
	logic [SAMPLE_BITS-1:0] phase_u_sample = '0;
	logic [SAMPLE_BITS-1:0] phase_v_sample = '0;
	logic [SAMPLE_BITS-1:0] phase_w_sample = '0;
	logic [SAMPLE_BITS-1:0] ref_u_sample = '0;
	logic [SAMPLE_BITS-1:0] ref_v_sample = '0;
	logic [SAMPLE_BITS-1:0] ref_w_sample = '0;

	// result channel
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic signed [OUT_W-1:0] d_current;
	logic signed [OUT_W-1:0] q_current;

	// predictor state: offsets with OFFSET_SHIFT fraction bits
	longint offs_u;
	longint offs_v;
	longint offs_w;
	int     sine_lut [0:SINE_TABLE_DEPTH];

	dq_word_t dq_expected [$];
	int       mismatches = 0;

	// traffic shaping flags set by the test tasks
	bit calm = 1'b0;		// no idling on either side
	bit holdoff_req = 1'b0;	// receiver starts a long hold-off
	int holdoff_left = 0;

	phase_current_dq_transform DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.angle          (angle),
		.phase_u_sample (phase_u_sample),
		.phase_v_sample (phase_v_sample),
		.phase_w_sample (phase_w_sample),
		.ref_u_sample   (ref_u_sample),
		.ref_v_sample   (ref_v_sample),
		.ref_w_sample   (ref_w_sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.d_current      (d_current),
		.q_current      (q_current)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// quarter-wave entry: odd taylor series of sin in q30, truncating each
	// term, then rounded half up to q15 and capped at 1.0
	function automatic int taylor_quarter_sine(input int pos);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] acc;
		logic [63:0] r;
		x = (64'd1686629713 * 64'(pos)) / 64'(SINE_TABLE_DEPTH);
		term = x;
		acc = x;
		for (int k = 1; k <= 6; k++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / 64'((2 * k) * (2 * k + 1));
			if (k % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		r = (acc + 64'd16384) >> 15;
		if (r > 64'd32768)
			r = 64'd32768;
		return int'(r);
	endfunction

	// signed q15 sine, top two angle bits pick the quadrant
	function automatic longint sine_at(input logic [ANGLE_W-1:0] a);
		logic [1:0] quad;
		int         idx;
		int         pos;
		longint     v;
		quad = a[ANGLE_W-1 -: 2];
		idx = (int'(a[ANGLE_W-3:0]) * SINE_TABLE_DEPTH) >> (ANGLE_W - 2);
		pos = quad[0] ? SINE_TABLE_DEPTH - idx : idx;
		v = longint'(sine_lut[pos]);
		return quad[1] ? -v : v;
	endfunction

	// offset += floor(((level << shift) - offset) / 2^shift)
	function automatic longint advance_offset(input longint off,
			input logic [SAMPLE_BITS-1:0] lvl);
		longint diff;
		diff = (longint'(lvl) <<< OFFSET_SHIFT) - off;
		return off + (diff >>> OFFSET_SHIFT);
	endfunction

	// round half toward +inf, then clamp to the output range
	function automatic logic signed [OUT_W-1:0] scale_and_clamp(input longint acc);
		longint v;
		v = (acc + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
		if (v > OUT_HI)
			v = OUT_HI;
		if (v < OUT_LO)
			v = OUT_LO;
		return v[OUT_W-1:0];
	endfunction

	// offsets first, then correction and the d/q sums; U is a, W is b, V is c
	function automatic dq_word_t predict_dq(input sample_word_t w);
		longint   a;
		longint   b;
		longint   c;
		longint   x;
		longint   y;
		longint   sf;
		longint   cf;
		dq_word_t r;
		offs_u = advance_offset(offs_u, w.ru);
		offs_v = advance_offset(offs_v, w.rv);
		offs_w = advance_offset(offs_w, w.rw);
		a = (longint'(w.pu) <<< OFFSET_SHIFT) - offs_u;
		c = (longint'(w.pv) <<< OFFSET_SHIFT) - offs_v;
		b = (longint'(w.pw) <<< OFFSET_SHIFT) - offs_w;
		x = (2 * a - b - c) * THIRD_W;
		y = (b - c) * ISQRT3_W;
		sf = sine_at(w.angle);
		cf = sine_at(w.angle + 16'(1 << (ANGLE_W - 2)));
		r.d = scale_and_clamp(cf * x + sf * y);
		r.q = scale_and_clamp(cf * y - sf * x);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------------

	// offer one word, wait for acceptance, predict it, then maybe go idle
	task automatic send_word(input sample_word_t w);
		@(negedge clk);
		angle <= w.angle;
		phase_u_sample <= w.pu;
		phase_v_sample <= w.pv;
		phase_w_sample <= w.pw;
		ref_u_sample <= w.ru;
		ref_v_sample <= w.rv;
		ref_w_sample <= w.rw;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		dq_expected.push_back(predict_dq(w));
		// idle gaps of varying length so they land on every sequencer step
		if (!calm && $urandom_range(99) < 28) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat ($urandom_range(17)) @(negedge clk);
		end
	endtask

	function automatic sample_word_t make_word(input int a, input int pu, input int pv,
			input int pw, input int ru, input int rv, input int rw);
		sample_word_t w;
		w.angle = a[ANGLE_W-1:0];
		w.pu = pu[SAMPLE_BITS-1:0];
		w.pv = pv[SAMPLE_BITS-1:0];
		w.pw = pw[SAMPLE_BITS-1:0];
		w.ru = ru[SAMPLE_BITS-1:0];
		w.rv = rv[SAMPLE_BITS-1:0];
		w.rw = rw[SAMPLE_BITS-1:0];
		return w;
	endfunction

	function automatic int clip_level(input int v);
		if (v < 0)
			return 0;
		if (v > LEVEL_MAX)
			return LEVEL_MAX;
		return v;
	endfunction

	// reference level for a burst, with a fair share of the rails
	function automatic int pick_level();
		case ($urandom_range(9))
			0: return 0;
			1: return LEVEL_MAX;
			default: return $urandom_range(LEVEL_MAX);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// receiver: random stalls plus one long hold-off counted here
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			result_stall <= 1'b1;
		end else if (holdoff_req) begin
			holdoff_req <= 1'b0;
			holdoff_left <= HOLDOFF_LEN - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 28);
		end
	end

	// result checker, oldest prediction first
	always @(posedge clk) begin
		dq_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (dq_expected.size() == 0) begin
				$error("unexpected result word: d_current %0d, q_current %0d",
					d_current, q_current);
				mismatches++;
			end else begin
				want = dq_expected.pop_front();
				if (d_current !== want.d) begin
					$error("d_current: expected %0d, got %0d", want.d, d_current);
					mismatches++;
				end
				if (q_current !== want.q) begin
					$error("q_current: expected %0d, got %0d", want.q, q_current);
					mismatches++;
				end
			end
		end
	end

	// watchdog: ends the run if no word moves on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("phase_current_dq_transform_tb: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// references at zero keep the offsets at zero, so raw readings pass
	// straight into the transform; rails and axis angles
	task automatic test_zero_reference();
		send_word(make_word(0, LEVEL_MAX, 0, 0, 0, 0, 0));
		send_word(make_word(16384, 0, LEVEL_MAX, LEVEL_MAX, 0, 0, 0));
		send_word(make_word(32768, LEVEL_MAX, 0, LEVEL_MAX, 0, 0, 0));
		send_word(make_word(49152, 0, LEVEL_MAX, 0, 0, 0, 0));
		send_word(make_word(65535, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 0, 0, 0));
		send_word(make_word(0, 0, 0, 0, 0, 0, 0));
	endtask

	// full-scale reference step up, then back down: offsets climb toward
	// the top of their range and then fall with floor rounding of a
	// negative difference
	task automatic test_offset_step();
		int n;
		for (n = 0; n < 8; n++)
			send_word(make_word(8192 * n + 4095, (n % 2) ? LEVEL_MAX : 0,
				(n % 3 == 0) ? LEVEL_MAX : 0, (n % 2) ? 0 : LEVEL_MAX,
				LEVEL_MAX, LEVEL_MAX, LEVEL_MAX));
		for (n = 0; n < 4; n++)
			send_word(make_word(61440 - 4096 * n, LEVEL_MAX, 0, LEVEL_MAX, 0, 0,
				(n < 2) ? LEVEL_MAX : 0));
	endtask

	// angles next to the quadrant seams and just below the first table step
	task automatic test_quadrant_edges();
		int seams [6] = '{16383, 32767, 32768, 49151, 1, 15};
		foreach (seams[i])
			send_word(make_word(seams[i], $urandom_range(LEVEL_MAX),
				$urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX),
				$urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX),
				$urandom_range(LEVEL_MAX)));
	endtask

	// mostly rotor-like bursts: steady references, phases wandering around
	// them and an advancing angle; the rest is unrelated noise words
	task automatic test_random_mix(input int count);
		int                 sent;
		int                 burst;
		int                 lu;
		int                 lv;
		int                 lw;
		int                 amp;
		int                 spin;
		logic [ANGLE_W-1:0] ang;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(99) < 70) begin
				lu = pick_level();
				lv = pick_level();
				lw = pick_level();
				amp = $urandom_range(1) ? $urandom_range(64) : $urandom_range(LEVEL_MAX);
				spin = $urandom_range(4096);
				ang = ANGLE_W'($urandom);
				burst = $urandom_range(20, 60);
				repeat (burst) begin
					send_word(make_word(int'(ang),
						clip_level(lu + $urandom_range(2 * amp) - amp),
						clip_level(lv + $urandom_range(2 * amp) - amp),
						clip_level(lw + $urandom_range(2 * amp) - amp),
						clip_level(lu + $urandom_range(8) - 4),
						clip_level(lv + $urandom_range(8) - 4),
						clip_level(lw + $urandom_range(8) - 4)));
					ang = ang + spin[ANGLE_W-1:0];
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 8)) begin
					send_word(make_word($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom));
					sent++;
				end
			end
		end
	endtask

	// receiver holds off for a long stretch while words keep coming, so the
	// output register and the sequencer fill and the sample side stalls
	task automatic test_backpressure(input int count);
		@(negedge clk);
		holdoff_req <= 1'b1;
		test_random_mix(count);
	endtask

	// a stretch with no idling on either side, words back to back
	task automatic test_calm_stretch(input int count);
		calm = 1'b1;
		test_random_mix(count);
		calm = 1'b0;
	endtask

	initial begin
		for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
			sine_lut[i] = taylor_quarter_sine(i);
		offs_u = 0;
		offs_v = 0;
		offs_w = 0;

		// hold reset, then release it away from the rising edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_reference();
		test_offset_step();
		test_quadrant_edges();
		test_random_mix(1200);
		test_backpressure(60);
		test_calm_stretch(250);

		@(negedge clk);
		sample_valid <= 1'b0;

		// drain, then let the block settle past its latency
		while (dq_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("phase_current_dq_transform_tb: done, clean");
		else
			$display("phase_current_dq_transform_tb: done, errors");
		$finish;
	end

endmodule
